@@ rtl/nca_pkg.sv @@
// ----------------------------------------------------------------------------
// nca_pkg: shared definitions for nearest-centroid assignment
// Widths, field codes, sequencer states and squarer status.
// ----------------------------------------------------------------------------
package nca_pkg;

    // sizing
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 8;
    localparam int COORD_BITS   = 16;

    localparam int IDX_W       = $clog2(MAX_CLUSTERS);
    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int DCNT_W      = $clog2(MAX_DIMS + 1);
    localparam int STORE_DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int ADDR_W      = IDX_W + DIM_W;

    // interface field widths
    localparam int CSEL_W = 4;
    localparam int DSEL_W = 3;
    localparam int NC_W   = 5;
    localparam int DIST_W = 35;

    // arithmetic widths: |a - b| fits COORD_BITS unsigned bits
    localparam int MAG_W  = COORD_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ACC_W  = SQ_W + $clog2(MAX_DIMS);
    localparam int SCNT_W = $clog2(MAG_W);

    // beat kind on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_SQR,
        ST_CMP,
        ST_EMIT
    } nca_state_t;

    // squarer status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } nca_sqr_stat_t;

endpackage

@@ rtl/nca_ram.sv @@
// ----------------------------------------------------------------------------
// nca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/nca_sqr.sv @@
// ----------------------------------------------------------------------------
// nca_sqr: bit-serial squared difference
// Takes |a - b| and squares it by shift-and-add, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module nca_sqr
    import nca_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    output nca_sqr_stat_t                stat,
    output logic [SQ_W-1:0]              result
);

    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]        diff_abs;
    logic [MAG_W-1:0]           mag;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SCNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]   mcand_reg, mcand_next;
    logic [MAG_W-1:0]  mplier_reg, mplier_next;
    logic [SQ_W-1:0]   prod_reg, prod_next;

    // magnitude of the difference
    always_comb begin
        diff     = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        diff_abs = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
        mag      = diff_abs[MAG_W-1:0];
    end

    // shift-and-add step
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = SQ_W'(mag);
            mplier_next = mag;
            prod_next   = '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[SQ_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MAG_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == SCNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = prod_reg;

endmodule

@@ rtl/nearest_centroid_assign_top.sv @@
// A load beat is written to the store as it is accepted. A point beat runs, for each of the K
// active centroids, a RAM read, a squarer start and the bit-serial squarer in turn.
// On the last coordinate K compare steps and an emit step follow before m_tvalid rises.
// One item at a time: s_tready is high only in idle; the serial squarer sets the pace per centroid.
// Beats past the maximum dimension skip the squarer (and go on to compare if last).
// Reset (aresetn low, synchronous) idles the sequencer, drops m_tvalid, sets num_clusters 1.
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top: k-means assignment step
// Loads centroid coordinates into a store, accumulates squared distances of
// a streamed point to each centroid and emits the nearest centroid.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top
    import nca_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: num_clusters
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] centroid_sel, [6:4] dim_sel, [22:7] coord_value
    input  logic        s_tuser,   // [0] op
    input  logic        s_tlast,   // last_coord
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [3:0] cluster_index, [38:4] sq_distance
);

    nca_state_t state_reg, state_next;

    logic [NC_W-1:0]   num_clusters_reg;
    logic [IDX_W-1:0]  active_m1;
    logic [IDX_W-1:0]  c_reg;
    logic [DCNT_W-1:0] dim_cnt_reg;
    logic              last_reg;
    logic signed [COORD_BITS-1:0] coord_reg;

    logic [ACC_W-1:0]  acc_reg [MAX_CLUSTERS];
    logic [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    logic              m_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [DIST_W-1:0] out_dist_reg;

    logic [CSEL_W-1:0] s_csel;
    logic [DSEL_W-1:0] s_dsel;
    logic signed [COORD_BITS-1:0] s_coord;
    logic              s_accept;
    logic              s_excess;
    logic              pass_end;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [COORD_BITS-1:0] ram_rd_data;

    logic              sqr_start;
    nca_sqr_stat_t     sqr_stat;
    logic [SQ_W-1:0]   sqr_result;
    logic              out_load;

    // field unpacking
    assign s_csel  = s_tdata[CSEL_W-1:0];
    assign s_dsel  = s_tdata[CSEL_W+DSEL_W-1:CSEL_W];
    assign s_coord = s_tdata[CSEL_W+DSEL_W+COORD_BITS-1:CSEL_W+DSEL_W];

    assign s_accept = s_tvalid && s_tready;
    assign s_excess = (dim_cnt_reg == DCNT_W'(MAX_DIMS));
    assign pass_end = (state_reg == ST_SQR) && sqr_stat.done && (c_reg == active_m1);

    // active centroid count minus one, clamped to 1..MAX_CLUSTERS
    always_comb begin
        if (num_clusters_reg == '0) begin
            active_m1 = '0;
        end else if (num_clusters_reg > NC_W'(MAX_CLUSTERS)) begin
            active_m1 = IDX_W'(MAX_CLUSTERS - 1);
        end else begin
            active_m1 = IDX_W'(num_clusters_reg - 1'b1);
        end
    end

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg <= NC_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            num_clusters_reg <= cfg_data;
        end
    end

    // centroid store
    assign ram_wr_en   = s_accept && (s_tuser == OP_LOAD);
    assign ram_wr_addr = {s_csel[IDX_W-1:0], s_dsel[DIM_W-1:0]};
    assign ram_rd_addr = {c_reg, dim_cnt_reg[DIM_W-1:0]};

    nca_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_coord),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // serial squarer
    nca_sqr u_sqr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqr_start),
        .a       (coord_reg),
        .b       (ram_rd_data),
        .stat    (sqr_stat),
        .result  (sqr_result)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == OP_POINT) begin
                    if (!s_excess) begin
                        state_next = ST_READ;
                    end else if (s_tlast) begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_READ:  state_next = ST_START;
            ST_START: state_next = ST_SQR;
            ST_SQR: begin
                if (sqr_stat.done) begin
                    if (c_reg != active_m1) begin
                        state_next = ST_READ;
                    end else if (last_reg) begin
                        state_next = ST_CMP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMP: begin
                if (c_reg == active_m1) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_rd_en = 1'b0;
        sqr_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_READ:  ram_rd_en = 1'b1;
            ST_START: sqr_start = 1'b1;
            ST_SQR, ST_CMP: ;
            ST_EMIT:  out_load  = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            c_reg       <= '0;
            dim_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept && s_tuser == OP_POINT) begin
                c_reg <= '0;
                if (s_excess && s_tlast) begin
                    dim_cnt_reg <= '0;
                end
            end else if (state_reg == ST_SQR && sqr_stat.done) begin
                c_reg <= (c_reg == active_m1) ? '0 : c_reg + 1'b1;
            end else if (state_reg == ST_CMP) begin
                c_reg <= c_reg + 1'b1;
            end
            if (pass_end) begin
                dim_cnt_reg <= last_reg ? '0 : dim_cnt_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // running sum: first dimension starts a fresh sum
    assign acc_sum = ((dim_cnt_reg == '0) ? '0 : acc_reg[c_reg]) + ACC_W'(sqr_result);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == OP_POINT) begin
            coord_reg <= s_coord;
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_SQR && sqr_stat.done) begin
            acc_reg[c_reg] <= acc_sum;
        end
        // minimum search, strict less keeps the lowest index on ties
        if (state_reg == ST_CMP) begin
            if (c_reg == '0 || acc_reg[c_reg] < best_dist_reg) begin
                best_dist_reg <= acc_reg[c_reg];
                best_idx_reg  <= c_reg;
            end
        end
        if (out_load) begin
            out_idx_reg  <= best_idx_reg;
            out_dist_reg <= DIST_W'(best_dist_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_dist_reg, out_idx_reg};

    // checks
    a_sqr_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQR) |-> (sqr_stat.busy || sqr_stat.done))
        else $error("squarer idle while sequencer waits on it");

    a_dim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dim_cnt_reg <= DCNT_W'(MAX_DIMS))
        else $error("dimension counter past maximum");

    a_cmp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (c_reg <= active_m1))
        else $error("compare index beyond active centroids");

    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_POINT && s_tlast) |=> (state_reg != ST_IDLE))
        else $error("last coordinate did not start a pass");

    a_emit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

endmodule

@@ bench/nearest_centroid_assign_top_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top_tb: self-checking bench for the assignment step
// Loads the centroid store, streams points under several cluster counts and
// checks every emitted nearest centroid against a cycle-free predictor kept in
// step with the accepted input beats. Both stream sides idle at random; one
// long output stall fills the block and backs up its input.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top_tb;
    import nca_pkg::*;

    localparam int SETTLE_CYCLES = 400;      // worst point beat plus compare and emit
    localparam int HOLD_CYCLES   = 2000;     // long receiver stall
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int RANDOM_BEATS  = 60;       // per random setting
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [3:0] centroid_sel, [6:4] dim_sel, [22:7] coord_value
    logic        s_tuser;   // [0] op
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [3:0] cluster_index, [38:4] sq_distance

    nearest_centroid_assign_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    typedef struct {
        logic [IDX_W-1:0]  cluster;
        logic [DIST_W-1:0] sq_dist;
    } nearest_t;

    // predictor state
    logic signed [COORD_BITS-1:0] centroid_mem [MAX_CLUSTERS][MAX_DIMS];
    logic [ACC_W:0]               sum_by_centroid [MAX_CLUSTERS];
    int unsigned                  point_dim;
    logic [4:0]                   cfg_clusters;
    nearest_t                     nearest_q [$];

    int  errors      = 0;
    int  beat_count  = 0;
    int  cycle_count = 0;
    bit  idle_en     = 1'b1;
    bit  sink_hold   = 1'b0;

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL nearest_centroid_assign_top");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (errors < 100)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        errors++;
    endtask

    // Predictor: update the store or the per-centroid sums for one accepted beat
    // and queue the nearest centroid when the point ends.
    task automatic accumulate_and_assign(input logic op, input logic [CSEL_W-1:0] csel,
                                         input logic [DSEL_W-1:0] dsel,
                                         input logic signed [COORD_BITS-1:0] coord,
                                         input logic last);
        logic signed [COORD_BITS:0] diff;
        logic [COORD_BITS:0]        mag;
        logic [ACC_W:0]             best;
        int                         best_c;
        int                         active;
        nearest_t                   r;
        if (op == OP_LOAD) begin
            centroid_mem[csel][dsel] = coord;
            return;
        end
        // coordinates past the last dimension only count for last_coord
        if (point_dim < MAX_DIMS) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                diff = coord - centroid_mem[c][point_dim];
                mag  = diff[COORD_BITS] ? -diff : diff;
                sum_by_centroid[c] += mag * mag;
            end
            point_dim++;
        end
        if (!last)
            return;
        active = cfg_clusters;
        if (active < 1)
            active = 1;
        if (active > MAX_CLUSTERS)
            active = MAX_CLUSTERS;
        best   = sum_by_centroid[0];
        best_c = 0;
        // strict compare keeps the lowest index on a tie
        for (int c = 1; c < active; c++) begin
            if (sum_by_centroid[c] < best) begin
                best   = sum_by_centroid[c];
                best_c = c;
            end
        end
        r.cluster = IDX_W'(best_c);
        r.sq_dist = (best > DIST_MAX) ? DIST_MAX : best[DIST_W-1:0];
        nearest_q = {nearest_q, r};
        for (int c = 0; c < MAX_CLUSTERS; c++)
            sum_by_centroid[c] = '0;
        point_dim = 0;
    endtask

    // Offer one beat, wait for the handshake, then update the prediction.
    task automatic send_beat(input logic op, input logic [CSEL_W-1:0] csel,
                             input logic [DSEL_W-1:0] dsel,
                             input logic signed [COORD_BITS-1:0] coord, input logic last);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {1'b0, coord, dsel, csel};
        do @(posedge aclk); while (!s_tready);
        beat_count++;
        accumulate_and_assign(op, csel, dsel, coord, last);
    endtask

    // Wait until every result is back and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (nearest_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_clusters(input logic [4:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        cfg_clusters = value;
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CSEL_W-1:0] rand_csel();
        return CSEL_W'($urandom);
    endfunction

    function automatic logic [DSEL_W-1:0] rand_dsel();
        return DSEL_W'($urandom);
    endfunction

    // One point of random length, sometimes with loads interleaved or stray loads.
    task automatic send_random_point(input bit allow_excess);
        int ndims;
        if ($urandom_range(0, 9) < 2) begin
            send_beat(OP_LOAD, rand_csel(), rand_dsel(), rand_coord(), 1'($urandom));
            return;
        end
        ndims = $urandom_range(1, MAX_DIMS);
        if (allow_excess && $urandom_range(0, 9) == 0)
            ndims = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 3);
        for (int d = 0; d < ndims; d++) begin
            if ($urandom_range(0, 11) == 0)
                send_beat(OP_LOAD, rand_csel(), rand_dsel(), rand_coord(), 1'($urandom));
            send_beat(OP_POINT, rand_csel(), rand_dsel(), rand_coord(), d == ndims - 1);
        end
    endtask

    // Receiver ready: random bursts, the long hold on request, steady when idling is off.
    initial begin : sink_ready
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 7)) @(posedge aclk);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        nearest_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (nearest_q.size() == 0) begin
                report_mismatch("unexpected result beat", 0, m_tdata);
            end else begin
                want = nearest_q.pop_front();
                if (m_tdata[3:0] !== want.cluster)
                    report_mismatch("cluster_index", want.cluster, m_tdata[3:0]);
                if (m_tdata[38:4] !== want.sq_dist)
                    report_mismatch("sq_distance", want.sq_dist, m_tdata[38:4]);
            end
        end
    end

    // Fill the whole store: centroid 0 at the minimum, centroid 1 at the maximum.
    task automatic test_load_store();
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int d = 0; d < MAX_DIMS; d++)
                send_beat(OP_LOAD, CSEL_W'(c), DSEL_W'(d),
                          (c == 0) ? 16'sh8000 : (c == 1) ? 16'sh7fff : rand_coord(),
                          1'($urandom));
    endtask

    // Zero count acts as one; full-scale point past the last dimension gives the
    // largest distance; single-coordinate points at both extremes.
    task automatic test_extreme_distance();
        set_clusters(5'd0);
        for (int d = 0; d < MAX_DIMS + 2; d++)
            send_beat(OP_POINT, '1, '1, 16'sh7fff, d == MAX_DIMS + 1);
        set_clusters(5'd2);
        send_beat(OP_POINT, '0, '0, 16'sh8000, 1'b1);
        send_beat(OP_POINT, '0, '0, 16'sh7fff, 1'b1);
    endtask

    // Count above the maximum saturates; equal distances pick the lower index.
    task automatic test_tie_lowest_index();
        set_clusters(5'd31);
        send_beat(OP_LOAD, 4'd9, 3'd0, 16'sd7, 1'b0);
        send_beat(OP_LOAD, 4'd5, 3'd0, 16'sd7, 1'b1);
        send_beat(OP_POINT, 4'd0, 3'd0, 16'sd7, 1'b1);
    endtask

    // A load inside a point is used by the later coordinates; its last flag is ignored.
    task automatic test_load_within_point();
        set_clusters(5'd16);
        send_beat(OP_POINT, 4'd0, 3'd0, 16'sd100, 1'b0);
        send_beat(OP_LOAD, 4'd3, 3'd1, -16'sd5, 1'b1);
        send_beat(OP_POINT, 4'd0, 3'd0, -16'sd5, 1'b1);
    endtask

    task automatic test_random_settings();
        logic [4:0] settings [8] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd0, 5'd0};
        int         target;
        settings[6] = 5'($urandom_range(1, 16));
        settings[7] = 5'($urandom_range(0, 31));
        foreach (settings[i]) begin
            set_clusters(settings[i]);
            target = beat_count + RANDOM_BEATS;
            while (beat_count < target)
                send_random_point(1'b1);
        end
    endtask

    // Long receiver stall while short points keep coming in.
    task automatic test_output_stall();
        set_clusters(5'd1);
        sink_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            send_beat(OP_POINT, rand_csel(), rand_dsel(), rand_coord(), 1'b1);
    endtask

    // Back-to-back beats on both sides.
    task automatic test_steady_stream();
        int target;
        set_clusters(5'($urandom_range(1, 16)));
        idle_en = 1'b0;
        target  = beat_count + 120;
        while (beat_count < target)
            send_random_point(1'b1);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOAD;
        s_tlast   <= 1'b0;
        for (int c = 0; c < MAX_CLUSTERS; c++)
            sum_by_centroid[c] = '0;
        point_dim    = 0;
        cfg_clusters = 5'd1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_load_store();
        test_extreme_distance();
        test_tie_lowest_index();
        test_load_within_point();
        test_random_settings();
        test_output_stall();
        test_steady_stream();

        drain();
        if (errors == 0)
            $display("PASS nearest_centroid_assign_top");
        else
            $display("FAIL nearest_centroid_assign_top");
        $finish;
    end

endmodule
